FILE: hdl/jsef_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsef_pkg
// Shared types and constants for the JPEG SOI/EOI framer.
// ----------------------------------------------------------------------------
package jsef_pkg;

    // Width of the slot byte counter
    localparam int COUNT_BITS = 16;
    // Width used for slot limit compares (never narrower than the register)
    localparam int LIM_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [LIM_W-1:0] COUNT_MAX = LIM_W'({COUNT_BITS{1'b1}});

    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_EOI    = 8'hD9;

    // Register map: byte address bit 2 selects the register
    localparam logic REG_BUFFER_SIZE = 1'b0;
    localparam logic [15:0] BUFFER_SIZE_RST = 16'd40960;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_CLOSED    = 3'd2,
        ST_BAD_HDR   = 3'd3,
        ST_NO_FOOTER = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_PAD    = 3'b100
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic        store_valid;
        logic [15:0] store_index;
        logic [7:0]  store_byte;
        t_status     status;
        logic [15:0] jpeg_len;
        logic        last;
    } t_result;

    // Up to three result words for one input word
    typedef struct packed {
        t_result [2:0] res;
        logic [1:0]    count;
    } t_burst;

endpackage
`default_nettype wire

FILE: hdl/jsef_in_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsef_in_skid
// Input register with a skid entry, so that stall is a plain register.
// ----------------------------------------------------------------------------
module jsef_in_skid (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_kind,
    input  wire logic [7:0]     i_data_byte,
    output logic                o_stall,
    input  wire logic           i_take,
    output logic                o_head_valid,
    output jsef_pkg::t_item     o_head
);

    logic            r_main_valid, n_main_valid;
    logic            r_skid_valid, n_skid_valid;
    jsef_pkg::t_item r_main, n_main;
    jsef_pkg::t_item r_skid, n_skid;
    jsef_pkg::t_item w_new;
    logic            w_acc;

    assign w_new.kind      = i_kind;
    assign w_new.data_byte = i_data_byte;
    assign w_acc           = i_valid && !r_skid_valid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (i_take) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main       = w_new;
                n_main_valid = w_acc;
            end
        end else if (w_acc) begin
            if (r_main_valid) begin
                n_skid       = w_new;
                n_skid_valid = 1'b1;
            end else begin
                n_main       = w_new;
                n_main_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_stall      = r_skid_valid;
    assign o_head_valid = r_main_valid;
    assign o_head       = r_main;

endmodule
`default_nettype wire

FILE: hdl/jsef_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsef_step
// Frame state and the per-word marker check; builds the result burst.
// ----------------------------------------------------------------------------
module jsef_step (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire jsef_pkg::t_item i_item,
    input  wire logic [15:0]     i_buffer_size,
    output jsef_pkg::t_burst     o_burst
);

    localparam int CB = jsef_pkg::COUNT_BITS;
    localparam int LW = jsef_pkg::LIM_W;

    jsef_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_hdr_cnt, n_hdr_cnt;
    logic [7:0]       r_hdr0, n_hdr0;
    logic [7:0]       r_hdr1, n_hdr1;
    logic [CB-1:0]    r_byte_cnt, n_byte_cnt;
    logic             r_marker, n_marker;
    logic [CB-1:0]    r_found_len, n_found_len;

    logic [LW-1:0]    w_bsize;
    logic [LW-1:0]    w_limit;
    logic [CB-1:0]    w_cnt_inc;
    logic             w_full;
    logic             w_found;
    logic [7:0]       w_b;
    jsef_pkg::t_burst w_burst;

    assign w_bsize   = LW'(i_buffer_size);
    assign w_limit   = (w_bsize < jsef_pkg::COUNT_MAX) ? w_bsize : jsef_pkg::COUNT_MAX;
    assign w_b       = i_item.data_byte;
    assign w_cnt_inc = r_byte_cnt + 1'b1;
    assign w_full    = LW'(w_cnt_inc) >= w_limit;
    assign w_found   = r_marker && (w_b == jsef_pkg::MARK_EOI);

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr0      = r_hdr0;
        n_hdr1      = r_hdr1;
        n_byte_cnt  = r_byte_cnt;
        n_marker    = r_marker;
        n_found_len = r_found_len;
        w_burst     = '0;
        w_burst.count = 2'd1;
        w_burst.res[0].last   = 1'b1;
        w_burst.res[0].status = jsef_pkg::ST_BUSY;
        w_burst.res[1].status = jsef_pkg::ST_BUSY;
        w_burst.res[2].status = jsef_pkg::ST_BUSY;

        if (i_item.kind) begin
            n_phase     = jsef_pkg::PH_HEADER;
            n_hdr_cnt   = '0;
            n_hdr0      = '0;
            n_hdr1      = '0;
            n_byte_cnt  = '0;
            n_marker    = 1'b0;
            n_found_len = '0;
            w_burst.res[0].status = jsef_pkg::ST_CLOSED;
        end else begin
            unique case (r_phase)
                jsef_pkg::PH_HEADER: begin
                    if (r_hdr_cnt != 2'd2) begin
                        // hold the first two header bytes
                        if (r_hdr_cnt[0]) n_hdr1 = w_b;
                        else              n_hdr0 = w_b;
                        n_hdr_cnt = r_hdr_cnt + 2'd1;
                    end else if (r_hdr0 != jsef_pkg::MARK_PREFIX
                              || r_hdr1 != jsef_pkg::MARK_SOI
                              || w_b != jsef_pkg::MARK_PREFIX) begin
                        n_hdr_cnt = '0;
                        n_hdr0    = '0;
                        n_hdr1    = '0;
                        w_burst.res[0].status = jsef_pkg::ST_BAD_HDR;
                    end else begin
                        w_burst.count = 2'd3;
                        w_burst.res[0].store_valid = 1'b1;
                        w_burst.res[0].store_index = 16'd0;
                        w_burst.res[0].store_byte  = r_hdr0;
                        w_burst.res[0].last        = 1'b0;
                        w_burst.res[1].store_valid = 1'b1;
                        w_burst.res[1].store_index = 16'd1;
                        w_burst.res[1].store_byte  = r_hdr1;
                        w_burst.res[2].store_valid = 1'b1;
                        w_burst.res[2].store_index = 16'd2;
                        w_burst.res[2].store_byte  = w_b;
                        w_burst.res[2].last        = 1'b1;
                        n_hdr_cnt = '0;
                        n_hdr0    = '0;
                        n_hdr1    = '0;
                        if (w_limit <= LW'(3)) begin
                            w_burst.res[2].status = jsef_pkg::ST_NO_FOOTER;
                        end else begin
                            n_phase    = jsef_pkg::PH_BODY;
                            n_byte_cnt = CB'(3);
                            n_marker   = 1'b0;
                        end
                    end
                end
                jsef_pkg::PH_BODY: begin
                    w_burst.res[0].store_valid = 1'b1;
                    w_burst.res[0].store_index = 16'(r_byte_cnt);
                    w_burst.res[0].store_byte  = w_b;
                    n_byte_cnt = w_cnt_inc;
                    // FF FF keeps the marker armed
                    n_marker = !w_found && (w_b == jsef_pkg::MARK_PREFIX);
                    if (w_found && w_full) begin
                        w_burst.res[0].status   = jsef_pkg::ST_COMPLETE;
                        w_burst.res[0].jpeg_len = 16'(w_cnt_inc);
                    end else if (w_found) begin
                        n_found_len = w_cnt_inc;
                        n_phase     = jsef_pkg::PH_PAD;
                    end else if (w_full) begin
                        w_burst.res[0].status = jsef_pkg::ST_NO_FOOTER;
                    end
                    if (w_full) begin
                        n_phase     = jsef_pkg::PH_HEADER;
                        n_byte_cnt  = '0;
                        n_marker    = 1'b0;
                        n_found_len = '0;
                    end
                end
                default: begin
                    w_burst.res[0].store_valid = 1'b1;
                    w_burst.res[0].store_index = 16'(r_byte_cnt);
                    w_burst.res[0].store_byte  = w_b;
                    n_byte_cnt = w_cnt_inc;
                    if (w_full) begin
                        w_burst.res[0].status   = jsef_pkg::ST_COMPLETE;
                        w_burst.res[0].jpeg_len = 16'(r_found_len);
                        n_phase     = jsef_pkg::PH_HEADER;
                        n_byte_cnt  = '0;
                        n_marker    = 1'b0;
                        n_found_len = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= jsef_pkg::PH_HEADER;
            r_hdr_cnt   <= '0;
            r_hdr0      <= '0;
            r_hdr1      <= '0;
            r_byte_cnt  <= '0;
            r_marker    <= 1'b0;
            r_found_len <= '0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_hdr0      <= n_hdr0;
            r_hdr1      <= n_hdr1;
            r_byte_cnt  <= n_byte_cnt;
            r_marker    <= n_marker;
            r_found_len <= n_found_len;
        end
    end

    assign o_burst = w_burst;

endmodule
`default_nettype wire

FILE: hdl/jsef_out_burst.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsef_out_burst
// Result register: holds one burst and plays it out one word per handshake.
// ----------------------------------------------------------------------------
module jsef_out_burst (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire jsef_pkg::t_burst i_burst,
    output logic                  o_can_load,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output jsef_pkg::t_result     o_res,
    output logic [1:0]            o_remain
);

    logic                    r_valid, n_valid;
    logic [1:0]              r_pos, n_pos;
    logic [1:0]              r_rem, n_rem;
    jsef_pkg::t_result [2:0] r_q, n_q;

    assign o_can_load = !r_valid || (!i_stall && r_rem == 2'd0);

    always_comb begin
        n_valid = r_valid;
        n_pos   = r_pos;
        n_rem   = r_rem;
        n_q     = r_q;
        if (i_load) begin
            n_q     = i_burst.res;
            n_pos   = 2'd0;
            n_rem   = i_burst.count - 2'd1;
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            if (r_rem != 2'd0) begin
                n_pos = r_pos + 2'd1;
                n_rem = r_rem - 2'd1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
            r_rem   <= '0;
        end else begin
            r_valid <= n_valid;
            r_pos   <= n_pos;
            r_rem   <= n_rem;
        end
        r_q <= n_q;
    end

    always_comb begin
        unique case (r_pos)
            2'd1:    o_res = r_q[1];
            2'd2:    o_res = r_q[2];
            default: o_res = r_q[0];
        endcase
    end

    assign o_valid  = r_valid;
    assign o_remain = r_rem;

endmodule
`default_nettype wire

FILE: hdl/jpeg_soi_eoi_framer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpeg_soi_eoi_framer_core
// Frames a byte stream into fixed-size JPEG slots, checking SOI and EOI.
// ----------------------------------------------------------------------------
// Each input word carries either a received byte or a stream-closed event.
// The first three bytes of a slot must be FF D8 FF; once they are, they come
// out as three store words at slot positions 0, 1 and 2. Later bytes come out
// as one store word each while the logic watches for FF D9; the position just
// past D9 is the image length. Padding bytes follow until buffer_size bytes
// have been stored, and the last store word of the slot reports completion
// with the image length. A slot that fills before the end marker reports a
// missing footer, a bad header reports status 3 with nothing stored, and a
// stream-closed word reports status 2 and restarts the slot. Every input word
// yields one result word, except the word that completes a good header, which
// yields three; o_last marks the final result word of each input word.
// Rate: one input word per cycle while the result channel is not stalled, one
// result word per cycle out. A good-header word holds the result register
// until its three result words have gone out, so the input side stalls once
// the two-entry input buffer fills. An accepted word passes through the input
// register, then the result register, on its way out. buffer_size (APB
// address 0, reset 40960) may only be written while no word is in flight.
// ----------------------------------------------------------------------------
module jpeg_soi_eoi_framer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_data_byte,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_store_valid,
    output logic [15:0]      o_store_index,
    output logic [7:0]       o_store_byte,
    output logic [2:0]       o_status,
    output logic [15:0]      o_jpeg_len,
    output logic             o_last
);

    logic [15:0]       r_buffer_size;
    logic              w_cfg_wr;
    logic              w_head_valid;
    jsef_pkg::t_item   w_head;
    logic              w_can_load;
    logic              w_adv;
    jsef_pkg::t_burst  w_burst;
    jsef_pkg::t_result w_res;
    logic [1:0]        w_remain;

    // Register write on the access phase
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == jsef_pkg::REG_BUFFER_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= jsef_pkg::BUFFER_SIZE_RST;
        end else if (w_cfg_wr) begin
            r_buffer_size <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == jsef_pkg::REG_BUFFER_SIZE) ? {16'd0, r_buffer_size} : 32'd0;

    // Input register plus skid entry
    jsef_in_skid u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .o_stall      (o_in_stall),
        .i_take       (w_adv),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // Advance the frame state when the result register can take a new burst
    assign w_adv = w_head_valid && w_can_load;

    jsef_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_item        (w_head),
        .i_buffer_size (r_buffer_size),
        .o_burst       (w_burst)
    );

    jsef_out_burst u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_adv),
        .i_burst    (w_burst),
        .o_can_load (w_can_load),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_res      (w_res),
        .o_remain   (w_remain)
    );

    assign o_store_valid  = w_res.store_valid;
    assign o_store_index  = w_res.store_index;
    assign o_store_byte   = w_res.store_byte;
    assign o_status       = w_res.status;
    assign o_jpeg_len     = w_res.jpeg_len;
    assign o_last         = w_res.last;

`ifndef SYNTHESIS
    // Words still queued in a burst imply a word is on show
    a_remain_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_remain != 2'd0) |-> o_out_valid)
        else $error("burst remainder without valid result");

    // Only the final word of a burst carries last
    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && w_remain != 2'd0) |-> !o_last)
        else $error("last raised before end of burst");

    // The input stall is raised only while the input register is occupied
    a_stall_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_head_valid)
        else $error("skid entry filled with empty input register");

    // Image length is reported only with completion
    a_len_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != jsef_pkg::ST_COMPLETE) |-> (o_jpeg_len == 16'd0))
        else $error("image length outside completion");
`endif

endmodule
`default_nettype wire
